// File: sv/lcdlb_pkg.sv
// Shared constants, types and the init sequence table for the character LCD line buffer driver.
package lcdlb_pkg;

    localparam int LINE_LENGTH = 16;
    localparam int LINE_COUNT  = 2;
    localparam int STORE_DEPTH = LINE_LENGTH * LINE_COUNT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COL_W       = $clog2(LINE_LENGTH + 1);
    localparam int PAD_W       = $clog2(STORE_DEPTH + 32);

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [1:0] WAIT_NONE = 2'd0;
    localparam logic [1:0] WAIT_40US = 2'd1;
    localparam logic [1:0] WAIT_1MS  = 2'd2;
    localparam logic [1:0] WAIT_10MS = 2'd3;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    localparam logic [3:0] NIB_WAKE  = 4'b0011;
    localparam logic [3:0] NIB_4BIT  = 4'b0010;
    localparam logic [7:0] CMD_FUNC_SET   = 8'b0010_1000;
    localparam logic [7:0] CMD_DISP_OFF   = 8'b0000_1000;
    localparam logic [7:0] CMD_CLEAR      = 8'b0000_0001;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'b0000_0110;
    localparam logic [7:0] CMD_DISP_ON    = 8'b0000_1100;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'b1000_0000;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    localparam int INIT_LEN   = 14;
    localparam int INIT_IDX_W = $clog2(INIT_LEN);

    typedef struct packed {
        logic [3:0] nibble;
        logic [1:0] wait_class;
    } init_nibble_t;

    // Requests from the sequencer to the text store.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              clr_all;
        logic              pad_en;
        logic [PAD_W-1:0]  pad_start;
        logic [PAD_W-1:0]  pad_end;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_cmd_t;

    // Power-on run: wake nibbles, 4-bit switch, then five commands as nibble pairs.
    function automatic init_nibble_t init_entry(input logic [INIT_IDX_W-1:0] idx);
        init_nibble_t e;
        e.wait_class = WAIT_NONE;
        e.nibble     = 4'h0;
        case (idx)
            4'd0:    begin e.nibble = NIB_WAKE;             e.wait_class = WAIT_10MS; end
            4'd1:    begin e.nibble = NIB_WAKE;             e.wait_class = WAIT_1MS;  end
            4'd2:    begin e.nibble = NIB_WAKE;             e.wait_class = WAIT_1MS;  end
            4'd3:    begin e.nibble = NIB_4BIT;             e.wait_class = WAIT_1MS;  end
            4'd4:    begin e.nibble = CMD_FUNC_SET[7:4];    e.wait_class = WAIT_NONE; end
            4'd5:    begin e.nibble = CMD_FUNC_SET[3:0];    e.wait_class = WAIT_1MS;  end
            4'd6:    begin e.nibble = CMD_DISP_OFF[7:4];    e.wait_class = WAIT_NONE; end
            4'd7:    begin e.nibble = CMD_DISP_OFF[3:0];    e.wait_class = WAIT_1MS;  end
            4'd8:    begin e.nibble = CMD_CLEAR[7:4];       e.wait_class = WAIT_NONE; end
            4'd9:    begin e.nibble = CMD_CLEAR[3:0];       e.wait_class = WAIT_1MS;  end
            4'd10:   begin e.nibble = CMD_ENTRY_MODE[7:4];  e.wait_class = WAIT_NONE; end
            4'd11:   begin e.nibble = CMD_ENTRY_MODE[3:0];  e.wait_class = WAIT_1MS;  end
            4'd12:   begin e.nibble = CMD_DISP_ON[7:4];     e.wait_class = WAIT_NONE; end
            4'd13:   begin e.nibble = CMD_DISP_ON[3:0];     e.wait_class = WAIT_1MS;  end
            default: begin e.nibble = 4'h0;                 e.wait_class = WAIT_NONE; end
        endcase
        return e;
    endfunction

endpackage

// File: sv/lcdlb_if.sv
// Valid/ready channel interfaces for driver requests and nibble results.
interface lcdlb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic       line;
    logic [4:0] position;
    logic [7:0] character;

    modport source (output valid, output operation, output line, output position,
                    output character, input ready);
    modport sink   (input valid, input operation, input line, input position,
                    input character, output ready);
endinterface

interface lcdlb_out_if;
    logic       valid;
    logic       ready;
    logic       register_select;
    logic [3:0] nibble;
    logic [1:0] wait_class;
    logic       last;

    modport source (output valid, output register_select, output nibble,
                    output wait_class, output last, input ready);
    modport sink   (input valid, input register_select, input nibble,
                    input wait_class, input last, output ready);
endinterface

// File: sv/lcdlb_text_store.sv
// Text store: character memory with per-entry valid flags and a registered read port.
module lcdlb_text_store
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcdlb_pkg::store_cmd_t cmd,
    output logic [7:0]            rd_char
);

    logic [7:0]                        mem [lcdlb_pkg::STORE_DEPTH];
    logic [lcdlb_pkg::STORE_DEPTH-1:0] valid_reg;
    logic [lcdlb_pkg::STORE_DEPTH-1:0] valid_next;
    logic [7:0]                        rd_data_reg;
    logic                              rd_valid_reg;

    // Entries without a valid flag read as a space.
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clr_all)
        begin
            valid_next = '0;
        end
        if (cmd.pad_en)
        begin
            for (int j = 0; j < lcdlb_pkg::STORE_DEPTH; j++)
            begin
                if (lcdlb_pkg::PAD_W'(j) >= cmd.pad_start &&
                    lcdlb_pkg::PAD_W'(j) < cmd.pad_end)
                begin
                    valid_next[j] = 1'b0;
                end
            end
        end
        if (cmd.wr_en)
        begin
            valid_next[cmd.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg  <= mem[cmd.rd_addr];
            rd_valid_reg <= valid_reg[cmd.rd_addr];
        end
    end

    assign rd_char = rd_valid_reg ? rd_data_reg : lcdlb_pkg::CHAR_SPACE;

endmodule

// File: sv/character_lcd_line_buffer_driver.sv
// Character LCD line buffer driver: request decode, nibble sequencer and output register.
// The first nibble of an init or finish run passes the state register, then the output register.
// One nibble per cycle unless the output stalls; init emits 14 nibbles, finish 2 + 2 * LINE_LENGTH (34).
// A store leaves the sequencer idle, so it does not hold up the next request; requests are
// taken only while the sequencer is idle. The pace is one nibble per cycle through the output
// register; a stalled output stalls the sequencer, and with it the input.
// Reset: asynchronous, active low; the text store reads all spaces after reset.
module character_lcd_line_buffer_driver
(
    input  logic        clk,
    input  logic        rst_n,
    lcdlb_in_if.sink    items,
    lcdlb_out_if.source results
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_CUR_HI = 3'd2;
    localparam logic [2:0] ST_CUR_LO = 3'd3;
    localparam logic [2:0] ST_DAT_HI = 3'd4;
    localparam logic [2:0] ST_DAT_LO = 3'd5;

    logic [2:0]                       state_reg, state_next;
    logic [lcdlb_pkg::INIT_IDX_W-1:0] cnt_reg, cnt_next;
    logic [lcdlb_pkg::COL_W-1:0]      col_reg, col_next;
    logic                             line_reg, line_next;

    logic       out_valid_reg, out_valid_next;
    logic       out_rs_reg;
    logic [3:0] out_nib_reg;
    logic [1:0] out_wait_reg;
    logic       out_last_reg;

    lcdlb_pkg::store_cmd_t   scmd;
    lcdlb_pkg::init_nibble_t init_e;
    logic [7:0]              rd_char;

    logic       accept;
    logic       line_ok, pos_ok;
    logic       emit, load;
    logic       em_rs, em_last;
    logic [3:0] em_nib;
    logic [1:0] em_wait;
    logic       last_col;
    logic [lcdlb_pkg::ADDR_W-1:0] in_base, run_base;
    logic [lcdlb_pkg::COL_W-1:0]  rd_col;

    assign items.ready = (state_reg == ST_IDLE);
    assign accept      = items.valid && items.ready;

    assign line_ok  = int'(items.line) < lcdlb_pkg::LINE_COUNT;
    assign pos_ok   = int'(items.position) < lcdlb_pkg::LINE_LENGTH;
    assign in_base  = items.line ? lcdlb_pkg::ADDR_W'(lcdlb_pkg::LINE_LENGTH) : '0;
    assign run_base = line_reg ? lcdlb_pkg::ADDR_W'(lcdlb_pkg::LINE_LENGTH) : '0;
    assign last_col = (col_reg == lcdlb_pkg::COL_W'(lcdlb_pkg::LINE_LENGTH - 1));
    assign init_e   = lcdlb_pkg::init_entry(cnt_reg);

    // Nibble the sequencer offers in its current state
    always_comb
    begin
        emit    = 1'b0;
        em_rs   = lcdlb_pkg::RS_CMD;
        em_nib  = 4'h0;
        em_wait = lcdlb_pkg::WAIT_NONE;
        em_last = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                emit    = 1'b1;
                em_nib  = init_e.nibble;
                em_wait = init_e.wait_class;
                em_last = (cnt_reg == lcdlb_pkg::INIT_IDX_W'(lcdlb_pkg::INIT_LEN - 1));
            end
            ST_CUR_HI:
            begin
                emit   = 1'b1;
                em_nib = lcdlb_pkg::CMD_SET_DDRAM[7:4] | {1'b0, line_reg, 2'b00};
            end
            ST_CUR_LO:
            begin
                emit    = 1'b1;
                em_nib  = lcdlb_pkg::CMD_SET_DDRAM[3:0];
                em_wait = lcdlb_pkg::WAIT_40US;
            end
            ST_DAT_HI:
            begin
                emit   = 1'b1;
                em_rs  = lcdlb_pkg::RS_DATA;
                em_nib = rd_char[7:4];
            end
            ST_DAT_LO:
            begin
                emit    = 1'b1;
                em_rs   = lcdlb_pkg::RS_DATA;
                em_nib  = rd_char[3:0];
                em_wait = lcdlb_pkg::WAIT_40US;
                em_last = last_col;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Output register takes a nibble when empty or when its current one transfers
    assign load           = emit && (!out_valid_reg || results.ready);
    assign out_valid_next = load || (out_valid_reg && !results.ready);

    // Sequencer and text store requests
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        col_next   = col_reg;
        line_next  = line_reg;
        rd_col     = '0;

        scmd           = '0;
        scmd.wr_addr   = in_base + lcdlb_pkg::ADDR_W'(items.position);
        scmd.wr_data   = items.character;
        scmd.pad_start = lcdlb_pkg::PAD_W'(in_base) + lcdlb_pkg::PAD_W'(items.position);
        scmd.pad_end   = lcdlb_pkg::PAD_W'(in_base) + lcdlb_pkg::PAD_W'(lcdlb_pkg::LINE_LENGTH);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (items.operation)
                        lcdlb_pkg::OP_INIT:
                        begin
                            scmd.clr_all = 1'b1;
                            cnt_next     = '0;
                            state_next   = ST_INIT;
                        end
                        lcdlb_pkg::OP_STORE:
                        begin
                            scmd.wr_en = line_ok && pos_ok;
                        end
                        lcdlb_pkg::OP_FINISH:
                        begin
                            if (line_ok)
                            begin
                                // Padding just drops the flags; those entries read as spaces
                                scmd.pad_en = 1'b1;
                                line_next   = items.line;
                                state_next  = ST_CUR_HI;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                if (load)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (em_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CUR_HI:
            begin
                if (load)
                begin
                    state_next = ST_CUR_LO;
                end
            end
            ST_CUR_LO:
            begin
                if (load)
                begin
                    // Fetch column 0 so it is ready for the first data nibble
                    scmd.rd_en = 1'b1;
                    rd_col     = '0;
                    col_next   = '0;
                    state_next = ST_DAT_HI;
                end
            end
            ST_DAT_HI:
            begin
                if (load)
                begin
                    state_next = ST_DAT_LO;
                end
            end
            ST_DAT_LO:
            begin
                if (load)
                begin
                    if (last_col)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Low nibble leaves now; the next character is fetched alongside
                        scmd.rd_en = 1'b1;
                        rd_col     = col_reg + 1'b1;
                        col_next   = col_reg + 1'b1;
                        state_next = ST_DAT_HI;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        scmd.rd_addr = run_base + lcdlb_pkg::ADDR_W'(rd_col);
    end

    lcdlb_text_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (scmd),
        .rd_char (rd_char)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            col_reg       <= '0;
            line_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_rs_reg   <= em_rs;
            out_nib_reg  <= em_nib;
            out_wait_reg <= em_wait;
            out_last_reg <= em_last;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.register_select = out_rs_reg;
    assign results.nibble          = out_nib_reg;
    assign results.wait_class      = out_wait_reg;
    assign results.last            = out_last_reg;

endmodule

// File: sv/lcdlb_checker.sv
// Port-level checks for the character LCD line buffer driver, bound to the top level.
module lcdlb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_operation,
    input logic       in_line,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_rs,
    input logic [3:0] out_nibble,
    input logic [1:0] out_wait,
    input logic       out_last
);

    // A stalled nibble holds until it transfers
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_nibble) && $stable(out_last))
        else $error("result changed while stalled");

    // An init run blocks new requests in the following cycle
    a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_operation == lcdlb_pkg::OP_INIT |=> !in_ready)
        else $error("request taken during init run");

    // A finish on line 0 always starts a refresh run
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_operation == lcdlb_pkg::OP_FINISH && !in_line
        |=> !in_ready)
        else $error("request taken during refresh run");

    // Data nibbles wait at most 40 us
    a_data_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rs |->
        out_wait == lcdlb_pkg::WAIT_NONE || out_wait == lcdlb_pkg::WAIT_40US)
        else $error("bad wait class on data nibble");

    // The closing nibble of a run is always a low nibble with a wait
    a_last_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_wait != lcdlb_pkg::WAIT_NONE)
        else $error("last nibble without wait");

endmodule

bind character_lcd_line_buffer_driver lcdlb_checker u_lcdlb_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (items.valid),
    .in_ready     (items.ready),
    .in_operation (items.operation),
    .in_line      (items.line),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_rs       (results.register_select),
    .out_nibble   (results.nibble),
    .out_wait     (results.wait_class),
    .out_last     (results.last)
);

// File: tb/tb_top.sv
// Self-checking testbench for the character LCD line buffer driver.
module tb_top;
    import lcdlb_pkg::*;

    // The 2-bit operation field has one code the block does not use.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 260;  // effective requests in the random part
    localparam int LONG_HOLD    = 400;  // receiver hold-off, long enough to back up the input
    localparam int SETTLE       = 8;    // cycles after the last nibble before idle is assumed
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [1:0] op;
        logic       line;
        logic [4:0] pos;
        logic [7:0] chr;
    } lcd_req_t;

    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic [1:0] wc;
        logic       last;
    } lcd_nibble_t;

    // How the expected nibbles of a request are obtained.
    //   CHK_MODEL : from the line buffer predictor
    //   CHK_SILENT: typed in, the request must produce nothing
    //   CHK_FILL  : typed in, set-cursor then a full line of one character
    typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_FILL} chk_kind_t;

    typedef struct packed {
        lcd_req_t  req;
        chk_kind_t kind;
        logic [7:0] fill;
    } dir_row_t;

    localparam int DIR_ROWS = 19;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // straight out of reset both lines read blank
        '{'{OP_FINISH, 1'b0, 5'd0,  8'h00}, CHK_FILL,   CHAR_SPACE},
        // pad column past the line end: nothing padded, line still sent
        '{'{OP_FINISH, 1'b1, 5'd31, 8'h00}, CHK_FILL,   CHAR_SPACE},
        '{'{OP_INIT,   1'b0, 5'd0,  8'h00}, CHK_MODEL,  8'h00},
        // character extremes at both ends of line 0
        '{'{OP_STORE,  1'b0, 5'd0,  8'h00}, CHK_SILENT, 8'h00},
        '{'{OP_STORE,  1'b0, 5'd15, 8'hFF}, CHK_SILENT, 8'h00},
        // stores at or beyond the line length are dropped
        '{'{OP_STORE,  1'b1, 5'd16, 8'hAA}, CHK_SILENT, 8'h00},
        '{'{OP_STORE,  1'b1, 5'd31, 8'h55}, CHK_SILENT, 8'h00},
        // unused opcode, all other fields at their maximum
        '{'{OP_UNUSED, 1'b1, 5'd31, 8'hFF}, CHK_SILENT, 8'h00},
        '{'{OP_FINISH, 1'b0, 5'd16, 8'h00}, CHK_MODEL,  8'h00},
        '{'{OP_STORE,  1'b1, 5'd0,  8'h7F}, CHK_SILENT, 8'h00},
        '{'{OP_STORE,  1'b1, 5'd7,  8'h80}, CHK_SILENT, 8'h00},
        '{'{OP_STORE,  1'b1, 5'd8,  8'hA5}, CHK_SILENT, 8'h00},
        // padding from column 8 wipes the character stored there
        '{'{OP_FINISH, 1'b1, 5'd8,  8'h00}, CHK_MODEL,  8'h00},
        '{'{OP_FINISH, 1'b1, 5'd0,  8'h00}, CHK_FILL,   CHAR_SPACE},
        '{'{OP_STORE,  1'b0, 5'd3,  8'h41}, CHK_SILENT, 8'h00},
        // init blanks the whole store
        '{'{OP_INIT,   1'b1, 5'd31, 8'hFF}, CHK_MODEL,  8'h00},
        '{'{OP_FINISH, 1'b0, 5'd31, 8'h00}, CHK_FILL,   CHAR_SPACE},
        '{'{OP_UNUSED, 1'b0, 5'd0,  8'h00}, CHK_SILENT, 8'h00},
        '{'{OP_FINISH, 1'b0, 5'd0,  8'h00}, CHK_FILL,   CHAR_SPACE}
    };

    logic clk;
    logic rst_n;

    lcdlb_in_if  in_ch ();
    lcdlb_out_if out_ch ();

    character_lcd_line_buffer_driver dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (in_ch),
        .results (out_ch)
    );

    // Side information that travels with each request on the input channel.
    chk_kind_t  cur_kind;
    logic [7:0] cur_fill;

    // Predictor state: shadow of the text store.
    logic [7:0]  text_shadow [STORE_DEPTH];
    lcd_nibble_t run_q[$];           // nibbles of the request being predicted
    lcd_nibble_t nibble_expect_q[$]; // nibbles still owed by the block

    int errors;
    int nibbles_checked;
    int op_counts [4];
    int hold_reqs;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Line buffer predictor
    // ------------------------------------------------------------------
    function automatic void queue_nib(input logic rs, input logic [3:0] nib,
                                      input logic [1:0] wc);
        lcd_nibble_t n;
        n.rs   = rs;
        n.nib  = nib;
        n.wc   = wc;
        n.last = 1'b0;
        run_q.push_back(n);
    endfunction

    // A byte goes high nibble first; only the low nibble carries the wait.
    function automatic void queue_byte(input logic rs, input logic [7:0] b,
                                       input logic [1:0] wc);
        queue_nib(rs, b[7:4], WAIT_NONE);
        queue_nib(rs, b[3:0], wc);
    endfunction

    function automatic void predict_lcd_run(input lcd_req_t r);
        int base;
        base = int'(r.line) * LINE_LENGTH;
        case (r.op)
            OP_INIT:
            begin
                for (int i = 0; i < STORE_DEPTH; i++)
                    text_shadow[i] = CHAR_SPACE;
                // wake-up: first nibble gets the long wait, then 1 ms each
                queue_nib(RS_CMD, NIB_WAKE, WAIT_10MS);
                queue_nib(RS_CMD, NIB_WAKE, WAIT_1MS);
                queue_nib(RS_CMD, NIB_WAKE, WAIT_1MS);
                queue_nib(RS_CMD, NIB_4BIT, WAIT_1MS);
                queue_byte(RS_CMD, CMD_FUNC_SET,   WAIT_1MS);
                queue_byte(RS_CMD, CMD_DISP_OFF,   WAIT_1MS);
                queue_byte(RS_CMD, CMD_CLEAR,      WAIT_1MS);
                queue_byte(RS_CMD, CMD_ENTRY_MODE, WAIT_1MS);
                queue_byte(RS_CMD, CMD_DISP_ON,    WAIT_1MS);
            end
            OP_STORE:
            begin
                if (int'(r.line) < LINE_COUNT && int'(r.pos) < LINE_LENGTH)
                    text_shadow[base + int'(r.pos)] = r.chr;
            end
            OP_FINISH:
            begin
                if (int'(r.line) < LINE_COUNT)
                begin
                    for (int i = int'(r.pos); i < LINE_LENGTH; i++)
                        text_shadow[base + i] = CHAR_SPACE;
                    queue_byte(RS_CMD, CMD_SET_DDRAM | (8'(r.line) << 6), WAIT_40US);
                    for (int i = 0; i < LINE_LENGTH; i++)
                        queue_byte(RS_DATA, text_shadow[base + i], WAIT_40US);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input monitor: every accepted request feeds the predictor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lcd_req_t r;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            r.op   = in_ch.operation;
            r.line = in_ch.line;
            r.pos  = in_ch.position;
            r.chr  = in_ch.character;
            op_counts[r.op] = op_counts[r.op] + 1;
            run_q.delete();
            predict_lcd_run(r);
            // typed rows replace the predicted nibbles, state stays tracked
            if (cur_kind == CHK_SILENT)
                run_q.delete();
            else if (cur_kind == CHK_FILL)
            begin
                run_q.delete();
                queue_byte(RS_CMD, CMD_SET_DDRAM | (8'(r.line) << 6), WAIT_40US);
                for (int i = 0; i < LINE_LENGTH; i++)
                    queue_byte(RS_DATA, cur_fill, WAIT_40US);
            end
            if (run_q.size() > 0)
                run_q[run_q.size() - 1].last = 1'b1;
            foreach (run_q[i])
                nibble_expect_q.push_back(run_q[i]);
        end
    end

    // ------------------------------------------------------------------
    // Output checker: each nibble transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lcd_nibble_t got;
        lcd_nibble_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.rs   = out_ch.register_select;
            got.nib  = out_ch.nibble;
            got.wc   = out_ch.wait_class;
            got.last = out_ch.last;
            if (nibble_expect_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected nibble rs=%0b nib=%h wait=%0d last=%0b",
                         $time, got.rs, got.nib, got.wc, got.last);
            end
            else
            begin
                want = nibble_expect_q.pop_front();
                nibbles_checked++;
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: nibble mismatch: expected rs=%0b nib=%h wait=%0d last=%0b",
                             $time, want.rs, want.nib, want.wc, want.last);
                    $display("%0t:                  actual   rs=%0b nib=%h wait=%0d last=%0b",
                             $time, got.rs, got.nib, got.wc, got.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern changes mode after a randomly drawn stretch; a hold
    // request from the sender side forces a long stretch with ready low.
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int phase;
        int holds_seen;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        phase      = 0;
        holds_seen = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_seen)
            begin
                holds_seen = hold_reqs;
                hold_left  = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       out_ch.ready <= 1'b1;                         // no stalls
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));     // coin flip
                    2:       out_ch.ready <= ((phase % 4) != 3);          // 3 of 4
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0); // heavy stall
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d nibbles still expected",
                 cycle_count, nibble_expect_q.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    int burst_left;
    int useful_items;

    // Offer one request and hold it until the transfer. Bursts of random
    // length with random gaps; a zero gap keeps valid high across items.
    task automatic send_item(input lcd_req_t r, input chk_kind_t kind, input logic [7:0] fill);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= r.op;
        in_ch.line      <= r.line;
        in_ch.position  <= r.pos;
        in_ch.character <= r.chr;
        cur_kind        <= kind;
        cur_fill        <= fill;
        do
            @(posedge clk);
        while (!in_ch.ready);
        burst_left--;
        // ignored requests do not count toward the random budget
        if (!(r.op == OP_UNUSED || (r.op == OP_STORE && int'(r.pos) >= LINE_LENGTH)))
            useful_items++;
    endtask

    // Stop offering until every owed nibble has come out.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (nibble_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        lcd_req_t r;
        int pick;
        int start;
        int count;
        bit hold_done;
        bit pause_done;

        errors          = 0;
        nibbles_checked = 0;
        foreach (op_counts[i])
            op_counts[i] = 0;
        for (int i = 0; i < STORE_DEPTH; i++)
            text_shadow[i] = CHAR_SPACE;
        burst_left   = 0;
        useful_items = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;

        rst_n           <= 1'b0;
        hold_reqs       <= 0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_INIT;
        in_ch.line      <= 1'b0;
        in_ch.position  <= '0;
        in_ch.character <= '0;
        cur_kind        <= CHK_MODEL;
        cur_fill        <= '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIRECTED[i].req, DIRECTED[i].kind, DIRECTED[i].fill);
        drain_results();

        // Random part: mostly store runs closed by a finish, some init and noise
        useful_items = 0;
        while (useful_items < RANDOM_ITEMS)
        begin
            if (useful_items >= 120 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_reqs <= hold_reqs + 1;
            end
            if (useful_items >= 200 && !pause_done)
            begin
                pause_done = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                r.op   = OP_INIT;
                r.line = 1'($urandom_range(0, 1));
                r.pos  = 5'($urandom_range(0, 31));
                r.chr  = 8'($urandom_range(0, 255));
                send_item(r, CHK_MODEL, 8'h00);
            end
            else if (pick < 14)
            begin
                // noise: any field combination, unused opcode included
                r.op   = 2'($urandom_range(0, 3));
                r.line = 1'($urandom_range(0, 1));
                r.pos  = 5'($urandom_range(0, 31));
                r.chr  = 8'($urandom_range(0, 255));
                send_item(r, CHK_MODEL, 8'h00);
            end
            else
            begin
                // a text run on one line, then the finish that shows it
                r.line = 1'($urandom_range(0, 1));
                start  = $urandom_range(0, LINE_LENGTH - 1);
                count  = $urandom_range(1, LINE_LENGTH - start);
                for (int k = 0; k < count; k++)
                begin
                    r.op  = OP_STORE;
                    r.pos = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                        : 5'(start + k);
                    r.chr = 8'($urandom_range(0, 255));
                    send_item(r, CHK_MODEL, 8'h00);
                end
                r.op  = OP_FINISH;
                r.pos = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'(start + count);
                r.chr = 8'($urandom_range(0, 255));
                send_item(r, CHK_MODEL, 8'h00);
            end
        end

        drain_results();

        $display("Run summary: %0d init, %0d store, %0d finish, %0d unused requests",
                 op_counts[OP_INIT], op_counts[OP_STORE], op_counts[OP_FINISH],
                 op_counts[OP_UNUSED]);
        $display("Run summary: %0d nibbles checked, %0d mismatches, %0d left over",
                 nibbles_checked, errors, nibble_expect_q.size());
        if (errors == 0 && nibble_expect_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
sv/lcdlb_pkg.sv
sv/lcdlb_if.sv
sv/lcdlb_text_store.sv
sv/character_lcd_line_buffer_driver.sv
sv/lcdlb_checker.sv
tb/tb_top.sv
